// ===== rtl/rmad_pkg.sv =====
// Shared constants and types for the running median / deviation block.
package rmad_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int SUM_W    = VAL_W + CNT_W;
  localparam int TOT_W    = 52;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_FIN
  } state_t;

endpackage

// ===== rtl/running_median_abs_deviation.sv =====
// Sequencing: an insert walks down from the top of the store, reading each entry
// and moving it up one slot while it is greater than the new value, then writes
// the value into the slot left free (slot 0 if it reaches the bottom); a query
// sums entries 0..h, h = (count-1)/2, and waits in ST_Q_FIN for a free output.
// Throughput: one item at a time; the single RAM read port sets the rate.
// Reset: rst (synchronous) clears count, totals, overflow flag and control;
// the store needs no clearing, only entries below the count are ever read.
module running_median_abs_deviation
  import rmad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // value[31:0], bias[63:32]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // median[31:0], min_total[83:32], empty_res[84],
                                 // overflowed[85], zero[87:86]
);

  state_t state, state_next;

  // datapath registers
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] value_total;
  logic signed [SUM_W-1:0] bias_total;
  logic                    overflow_flag;
  logic [CNT_W-1:0]        idx;       // insert slot / query read index
  logic [CNT_W-1:0]        half;      // lower median position
  logic signed [VAL_W-1:0] ins_val;
  logic signed [SUM_W-1:0] low_sum;
  logic signed [VAL_W-1:0] med;
  logic                    q_empty;

  // result register
  logic signed [VAL_W-1:0] out_median;
  logic signed [TOT_W-1:0] out_total;
  logic                    out_empty;
  logic                    out_ovf;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  logic accept;
  logic out_free;
  logic ins_shift;     // stored entry is greater than the new value: move it up
  logic signed [TOT_W-1:0] total_calc;
  logic [CNT_W-1:0] count_m1;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign ins_shift = $signed(ram_rdata) > ins_val;
  assign count_m1  = count - CNT_W'(1);

  // bias + total - 2*low + median when the count is odd (from the two half sums)
  assign total_calc = TOT_W'(bias_total) + TOT_W'(value_total)
                      - (TOT_W'(low_sum) <<< 1)
                      + (count[0] ? TOT_W'(med) : TOT_W'(0));

  rmad_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == KIND_QUERY) begin
            state_next = (count == '0) ? ST_Q_FIN : ST_Q_RD;
          end else if (count != CNT_W'(CAPACITY)) begin
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (idx == '0) state_next = ST_IDLE;
        else state_next = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_next = ins_shift ? ST_INS_RD : ST_IDLE;
      end
      ST_Q_RD:  state_next = ST_Q_ACC;
      ST_Q_ACC: state_next = (idx == half) ? ST_Q_FIN : ST_Q_RD;
      ST_Q_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx[ADDR_W-1:0];
    ram_wdata = ins_val;
    ram_raddr = idx[ADDR_W-1:0];
    unique case (state) inside
      ST_IDLE:   s_tready = 1'b1;
      ST_INS_RD: begin
        ram_raddr = ADDR_W'(idx - CNT_W'(1));
        ram_we    = (idx == '0);          // empty below: drop value into slot 0
      end
      ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = ins_shift ? ram_rdata : ins_val;
      end
      ST_Q_RD, ST_Q_ACC, ST_Q_FIN: ;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      value_total   <= '0;
      bias_total    <= '0;
      overflow_flag <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      // load a new result, else drop the one just taken
      if (state == ST_Q_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == KIND_QUERY) begin
              idx     <= '0;
              half    <= count_m1 >> 1;
              low_sum <= '0;
              med     <= '0;
              q_empty <= (count == '0);
            end else if (count == CNT_W'(CAPACITY)) begin
              overflow_flag <= 1'b1;
            end else begin
              idx         <= count;
              ins_val     <= $signed(s_tdata[31:0]);
              value_total <= value_total + SUM_W'($signed(s_tdata[31:0]));
              bias_total  <= bias_total + SUM_W'($signed(s_tdata[63:32]));
            end
          end
        end
        ST_INS_RD: begin
          if (idx == '0) count <= count + CNT_W'(1);
        end
        ST_INS_CMP: begin
          if (ins_shift) idx <= idx - CNT_W'(1);
          else count <= count + CNT_W'(1);
        end
        ST_Q_ACC: begin
          low_sum <= low_sum + SUM_W'($signed(ram_rdata));
          if (idx == half) med <= $signed(ram_rdata);
          else idx <= idx + CNT_W'(1);
        end
        ST_Q_FIN: begin
          if (out_free) begin
            out_median <= med;
            out_total  <= total_calc;
            out_empty  <= q_empty;
            out_ovf    <= overflow_flag;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {2'b00, out_ovf, out_empty, out_total, out_median};

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |=> overflow_flag)
    else $error("overflow flag cleared without reset");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CNT_W'(1)))
    else $error("count moved by other than one");

  a_we_insert: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_INS_RD || state == ST_INS_CMP))
    else $error("store written outside an insert");
`endif

endmodule

// ===== rtl/rmad_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rmad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
